FILE: rtl/core/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared widths and codes of the two-class priority queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned ENTRY_W = KEY_W + TAG_W;

  // request codes
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_SERVE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_SERVED  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

endpackage

FILE: rtl/core/tcpq_ram.sv
// ----------------------------------------------------------------------------
// tcpq_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue
// strict two-class queue: urgent fifo ahead of a key-sorted ordinary store
// ----------------------------------------------------------------------------
// Both classes live in synchronous RAMs used as circular buffers. An urgent
// arrival, or an ordinary arrival into an empty store, is written from the
// idle state; a dropped arrival or a serve that finds nothing waiting is
// answered from there, or via the result state while the output stalls. A
// serve that pops an item reads the RAM, then gives the result from the serve
// state, which waits out an output stall. An ordinary arrival into a non-empty
// store walks down from the tail through the single read port of the ordinary
// RAM, moving each entry with a strictly greater key one place up, one entry
// per cycle, then writes the new entry into the gap. Equal keys keep arrival
// order. An arrival to a full store is dropped and reported with status 2. One
// request is handled at a time; a result waits in the output register while the next request is taken.
module two_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int unsigned URGENT_DEPTH   = 16,
  parameter int unsigned ORDINARY_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic             urgent_i,
  input  logic [KEY_W-1:0] arrival_key_i,
  input  logic [TAG_W-1:0] item_tag_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [TAG_W-1:0] served_tag_o,
  output logic             served_urgent_o
);

  localparam int unsigned UAW = $clog2(URGENT_DEPTH);
  localparam int unsigned UCW = $clog2(URGENT_DEPTH + 1);
  localparam int unsigned OAW = $clog2(ORDINARY_DEPTH);
  localparam int unsigned OCW = $clog2(ORDINARY_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_SRV  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  function automatic logic [UAW-1:0] u_add(logic [UAW-1:0] a, logic [UCW-1:0] n);
    logic [UCW:0] s;
    s = (UCW+1)'(a) + (UCW+1)'(n);
    if (s >= (UCW+1)'(URGENT_DEPTH)) s = s - (UCW+1)'(URGENT_DEPTH);
    return s[UAW-1:0];
  endfunction

  function automatic logic [OAW-1:0] o_add(logic [OAW-1:0] a, logic [OCW-1:0] n);
    logic [OCW:0] s;
    s = (OCW+1)'(a) + (OCW+1)'(n);
    if (s >= (OCW+1)'(ORDINARY_DEPTH)) s = s - (OCW+1)'(ORDINARY_DEPTH);
    return s[OAW-1:0];
  endfunction

  function automatic logic [OAW-1:0] o_dec(logic [OAW-1:0] a);
    logic [OAW-1:0] r;
    if (a == '0) r = OAW'(ORDINARY_DEPTH - 1);
    else r = a - OAW'(1);
    return r;
  endfunction

  logic [1:0]         state_q, state_d;
  logic [UAW-1:0]     u_head_q, u_head_d;
  logic [UCW-1:0]     u_cnt_q, u_cnt_d;
  logic [OAW-1:0]     o_head_q, o_head_d;
  logic [OCW-1:0]     o_cnt_q, o_cnt_d;
  logic [KEY_W-1:0]   ins_key_q, ins_key_d;
  logic [TAG_W-1:0]   ins_tag_q, ins_tag_d;
  logic [OAW-1:0]     ins_wp_q, ins_wp_d;
  logic [OCW-1:0]     ins_rel_q, ins_rel_d;
  logic               srv_urg_q, srv_urg_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [TAG_W-1:0]   res_tag_q, res_tag_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         status_q, status_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic               urg_q, urg_d;

  logic               in_acc;
  logic               out_free;

  logic               u_we, u_re;
  logic [UAW-1:0]     u_waddr, u_raddr;
  logic [TAG_W-1:0]   u_wdata, u_rdata;
  logic               o_we, o_re;
  logic [OAW-1:0]     o_waddr, o_raddr;
  logic [ENTRY_W-1:0] o_wdata, o_rdata;

  logic [OAW-1:0]     wp_tail;
  logic [OAW-1:0]     wp_next;
  logic [OCW-1:0]     rel_next;

  tcpq_ram #(
    .WIDTH(TAG_W),
    .DEPTH(URGENT_DEPTH)
  ) u_urgent_ram (
    .clk_i  (clk_i),
    .we_i   (u_we),
    .waddr_i(u_waddr),
    .wdata_i(u_wdata),
    .re_i   (u_re),
    .raddr_i(u_raddr),
    .rdata_o(u_rdata)
  );

  tcpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ORDINARY_DEPTH)
  ) u_ordinary_ram (
    .clk_i  (clk_i),
    .we_i   (o_we),
    .waddr_i(o_waddr),
    .wdata_i(o_wdata),
    .re_i   (o_re),
    .raddr_i(o_raddr),
    .rdata_o(o_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wp_tail  = o_add(o_head_q, o_cnt_q);
  assign wp_next  = o_dec(ins_wp_q);
  assign rel_next = ins_rel_q - OCW'(1);

  always_comb begin
    state_d      = state_q;
    u_head_d     = u_head_q;
    u_cnt_d      = u_cnt_q;
    o_head_d     = o_head_q;
    o_cnt_d      = o_cnt_q;
    ins_key_d    = ins_key_q;
    ins_tag_d    = ins_tag_q;
    ins_wp_d     = ins_wp_q;
    ins_rel_d    = ins_rel_q;
    srv_urg_d    = srv_urg_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    tag_d        = tag_q;
    urg_d        = urg_q;
    u_we         = 1'b0;
    u_waddr      = u_add(u_head_q, u_cnt_q);
    u_wdata      = item_tag_i;
    u_re         = 1'b0;
    u_raddr      = u_head_q;
    o_we         = 1'b0;
    o_waddr      = wp_tail;
    o_wdata      = {arrival_key_i, item_tag_i};
    o_re         = 1'b0;
    o_raddr      = o_head_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_SERVE) begin
            if (u_cnt_q != '0) begin
              u_re      = 1'b1;
              u_head_d  = u_add(u_head_q, UCW'(1));
              u_cnt_d   = u_cnt_q - UCW'(1);
              srv_urg_d = 1'b1;
              state_d   = S_SRV;
            end else if (o_cnt_q != '0) begin
              o_re      = 1'b1;
              o_head_d  = o_add(o_head_q, OCW'(1));
              o_cnt_d   = o_cnt_q - OCW'(1);
              srv_urg_d = 1'b0;
              state_d   = S_SRV;
            end else if (out_free) begin
              out_valid_d = 1'b1;
              status_d    = STATUS_EMPTY;
              tag_d       = '0;
              urg_d       = 1'b0;
            end else begin
              // output word still waiting, hold the result
              res_status_d = STATUS_EMPTY;
              res_tag_d    = '0;
              srv_urg_d    = 1'b0;
              state_d      = S_RES;
            end
          end else if (urgent_i) begin
            if (u_cnt_q == UCW'(URGENT_DEPTH)) begin
              if (out_free) begin
                out_valid_d = 1'b1;
                status_d    = STATUS_DROPPED;
                tag_d       = item_tag_i;
                urg_d       = 1'b1;
              end else begin
                res_status_d = STATUS_DROPPED;
                res_tag_d    = item_tag_i;
                srv_urg_d    = 1'b1;
                state_d      = S_RES;
              end
            end else begin
              u_we    = 1'b1;
              u_cnt_d = u_cnt_q + UCW'(1);
            end
          end else begin
            if (o_cnt_q == OCW'(ORDINARY_DEPTH)) begin
              if (out_free) begin
                out_valid_d = 1'b1;
                status_d    = STATUS_DROPPED;
                tag_d       = item_tag_i;
                urg_d       = 1'b0;
              end else begin
                res_status_d = STATUS_DROPPED;
                res_tag_d    = item_tag_i;
                srv_urg_d    = 1'b0;
                state_d      = S_RES;
              end
            end else if (o_cnt_q == '0) begin
              o_we    = 1'b1;
              o_cnt_d = OCW'(1);
            end else begin
              // start the walk down from the tail
              o_re      = 1'b1;
              o_raddr   = o_dec(wp_tail);
              o_cnt_d   = o_cnt_q + OCW'(1);
              ins_key_d = arrival_key_i;
              ins_tag_d = item_tag_i;
              ins_wp_d  = wp_tail;
              ins_rel_d = o_cnt_q;
              state_d   = S_INS;
            end
          end
        end
      end
      S_INS: begin
        o_waddr = ins_wp_q;
        if (ins_rel_q == '0 || o_rdata[ENTRY_W-1:TAG_W] <= ins_key_q) begin
          o_we    = 1'b1;
          o_wdata = {ins_key_q, ins_tag_q};
          state_d = S_IDLE;
        end else begin
          // entry with a greater key moves one place up
          o_we      = 1'b1;
          o_wdata   = o_rdata;
          ins_wp_d  = wp_next;
          ins_rel_d = rel_next;
          if (rel_next != '0) begin
            o_re    = 1'b1;
            o_raddr = o_dec(wp_next);
          end
        end
      end
      S_SRV: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_SERVED;
          tag_d       = srv_urg_q ? u_rdata : o_rdata[TAG_W-1:0];
          urg_d       = srv_urg_q;
          state_d     = S_IDLE;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          tag_d       = res_tag_q;
          urg_d       = srv_urg_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      u_head_q    <= '0;
      u_cnt_q     <= '0;
      o_head_q    <= '0;
      o_cnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      u_head_q    <= u_head_d;
      u_cnt_q     <= u_cnt_d;
      o_head_q    <= o_head_d;
      o_cnt_q     <= o_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_key_q    <= ins_key_d;
    ins_tag_q    <= ins_tag_d;
    ins_wp_q     <= ins_wp_d;
    ins_rel_q    <= ins_rel_d;
    srv_urg_q    <= srv_urg_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    status_q     <= status_d;
    tag_q        <= tag_d;
    urg_q        <= urg_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign served_tag_o    = tag_q;
  assign served_urgent_o = urg_q;

endmodule
